FILE: rtl/core/tfn_pkg.sv
package tfn_pkg;

   // Field widths of the words on the ports
   localparam int COORD_WIDTH  = 32;
   localparam int NORMAL_WIDTH = 16;

   // Internal widths
   localparam int EDGE_W    = COORD_WIDTH + 1;
   localparam int NORM_TOP  = 30;
   localparam int UNIT_FRAC = 30;
   localparam int BL_W      = $clog2(COORD_WIDTH + 1);
   localparam int NM_W      = NORM_TOP;
   localparam int SQ_W      = 2 * NM_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int NUM_W     = NM_W + UNIT_FRAC + 1;
   localparam int QUO_W     = ROOT_W;
   localparam int U_W       = QUO_W + 1;
   localparam int PROD_W    = 2 * U_W;
   localparam int ROUND_SH  = 2 * UNIT_FRAC - (NORMAL_WIDTH - 2);

   // Pipeline depth: edge register, unit edge, products, differences, output
   localparam int UE_LAT   = 4 + ROOT_W + 1 + QUO_W + 1;
   localparam int PIPE_LAT = 1 + UE_LAT + 3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ax;
      logic signed [COORD_WIDTH-1:0] ay;
      logic signed [COORD_WIDTH-1:0] az;
      logic signed [COORD_WIDTH-1:0] bx;
      logic signed [COORD_WIDTH-1:0] by;
      logic signed [COORD_WIDTH-1:0] bz;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_WIDTH-1:0] nx;
      logic signed [NORMAL_WIDTH-1:0] ny;
      logic signed [NORMAL_WIDTH-1:0] nz;
      logic                           degenerate;
   } rsp_type;

endpackage

FILE: rtl/core/tfn_sqrt_cell.sv
// One digit of the integer square root: brings down two radicand bits
module tfn_sqrt_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic [tfn_pkg::SUM_W-1:0]  x_up,
   input  logic [tfn_pkg::REM_W-1:0]  rem_up,
   input  logic [tfn_pkg::ROOT_W-1:0] root_up,
   output logic [tfn_pkg::SUM_W-1:0]  x_dn,
   output logic [tfn_pkg::REM_W-1:0]  rem_dn,
   output logic [tfn_pkg::ROOT_W-1:0] root_dn
);
   localparam int SUM_W  = tfn_pkg::SUM_W;
   localparam int REM_W  = tfn_pkg::REM_W;
   localparam int ROOT_W = tfn_pkg::ROOT_W;

   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  test;
   logic [REM_W+1:0]  diff;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;
   logic [SUM_W-1:0]  x_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   // trial subtract of 4*root+1
   always_comb begin
      trial = {rem_up, x_up[2*IDX+1 -: 2]};
      test  = {2'b00, root_up, 2'b01};
      diff  = trial - test;
      if (trial >= test) begin
         rem_in  = diff[REM_W-1:0];
         root_in = {root_up[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = trial[REM_W-1:0];
         root_in = {root_up[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_up;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign x_dn    = x_ff;
   assign rem_dn  = rem_ff;
   assign root_dn = root_ff;
endmodule

FILE: rtl/core/tfn_div_cell.sv
// One quotient bit of a restoring division
module tfn_div_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic [tfn_pkg::NUM_W-1:0]  num_up,
   input  logic [tfn_pkg::ROOT_W-1:0] den_up,
   input  logic [tfn_pkg::ROOT_W-1:0] rem_up,
   input  logic [tfn_pkg::QUO_W-1:0]  quo_up,
   output logic [tfn_pkg::NUM_W-1:0]  num_dn,
   output logic [tfn_pkg::ROOT_W-1:0] den_dn,
   output logic [tfn_pkg::ROOT_W-1:0] rem_dn,
   output logic [tfn_pkg::QUO_W-1:0]  quo_dn
);
   localparam int NUM_W  = tfn_pkg::NUM_W;
   localparam int ROOT_W = tfn_pkg::ROOT_W;
   localparam int QUO_W  = tfn_pkg::QUO_W;

   logic [ROOT_W:0]   trial;
   logic [ROOT_W:0]   diff;
   logic [ROOT_W-1:0] rem_in;
   logic [QUO_W-1:0]  quo_in;
   logic [NUM_W-1:0]  num_ff;
   logic [ROOT_W-1:0] den_ff;
   logic [ROOT_W-1:0] rem_ff;
   logic [QUO_W-1:0]  quo_ff;

   // shift in the next numerator bit, subtract divisor when it fits
   always_comb begin
      trial = {rem_up, num_up[IDX]};
      diff  = trial - {1'b0, den_up};
      if (trial >= {1'b0, den_up}) begin
         rem_in = diff[ROOT_W-1:0];
         quo_in = {quo_up[QUO_W-2:0], 1'b1};
      end else begin
         rem_in = trial[ROOT_W-1:0];
         quo_in = {quo_up[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_up;
      den_ff <= den_up;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign num_dn = num_ff;
   assign den_dn = den_ff;
   assign rem_dn = rem_ff;
   assign quo_dn = quo_ff;
endmodule

FILE: rtl/core/tfn_unit_edge.sv
// Scales one edge vector to unit length, Q.30 components
module tfn_unit_edge (
   input  logic                                 clock,
   input  logic [2:0][tfn_pkg::EDGE_W-1:0]      edge_vec,
   output logic [2:0][tfn_pkg::U_W-1:0]         unit_vec,
   output logic                                 degen
);
   localparam int CW        = tfn_pkg::COORD_WIDTH;
   localparam int EDGE_W    = tfn_pkg::EDGE_W;
   localparam int BL_W      = tfn_pkg::BL_W;
   localparam int NM_W      = tfn_pkg::NM_W;
   localparam int SQ_W      = tfn_pkg::SQ_W;
   localparam int SUM_W     = tfn_pkg::SUM_W;
   localparam int ROOT_W    = tfn_pkg::ROOT_W;
   localparam int REM_W     = tfn_pkg::REM_W;
   localparam int NUM_W     = tfn_pkg::NUM_W;
   localparam int QUO_W     = tfn_pkg::QUO_W;
   localparam int U_W       = tfn_pkg::U_W;
   localparam int UNIT_FRAC = tfn_pkg::UNIT_FRAC;

   typedef struct packed {
      logic [2:0][NM_W-1:0] nm;
      logic [2:0]           sign;
      logic                 degen;
   } side_type;

   typedef struct packed {
      logic [2:0] sign;
      logic       degen;
   } tag_type;

   // stage 1: magnitudes and bit length of the largest
   logic [2:0][CW-1:0] mag_in, mag_ff;
   logic [2:0]         sign_in, sign1_ff;
   logic [BL_W-1:0]    bl_in, bl_ff;
   logic [CW-1:0]      mag_or;
   logic [EDGE_W-1:0]  neg;

   always_comb begin
      neg    = '0;
      for (int i = 0; i < 3; i++) begin
         neg        = -edge_vec[i];
         sign_in[i] = edge_vec[i][EDGE_W-1];
         mag_in[i]  = sign_in[i] ? neg[CW-1:0] : edge_vec[i][CW-1:0];
      end
      mag_or = mag_in[0] | mag_in[1] | mag_in[2];
      bl_in  = '0;
      for (int b = 0; b < CW; b++) begin
         if (mag_or[b]) begin
            bl_in = BL_W'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      sign1_ff <= sign_in;
      bl_ff    <= bl_in;
   end

   // stage 2: common shift puts the top bit at NM_W-1
   logic [2:0][NM_W-1:0]  nm_in, nm2_ff, nm3_ff, nm4_ff;
   logic [CW+NM_W-1:0]    wide;
   logic [2:0]            sign2_ff, sign3_ff, sign4_ff;
   logic                  degen2_ff, degen3_ff, degen4_ff;

   always_comb begin
      wide = '0;
      for (int i = 0; i < 3; i++) begin
         wide     = {mag_ff[i], {NM_W{1'b0}}} >> bl_ff;
         nm_in[i] = wide[NM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      nm2_ff    <= nm_in;
      sign2_ff  <= sign1_ff;
      degen2_ff <= (bl_ff == '0);
   end

   // stage 3: squares
   logic [2:0][SQ_W-1:0] sq_in, sq_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = nm2_ff[i] * nm2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      nm3_ff    <= nm2_ff;
      sign3_ff  <= sign2_ff;
      degen3_ff <= degen2_ff;
   end

   // stage 4: sum of squares
   logic [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      sum_ff    <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      nm4_ff    <= nm3_ff;
      sign4_ff  <= sign3_ff;
      degen4_ff <= degen3_ff;
   end

   // square root, one result bit per cell
   logic [SUM_W-1:0]  x_c    [ROOT_W+1];
   logic [REM_W-1:0]  rem_c  [ROOT_W+1];
   logic [ROOT_W-1:0] root_c [ROOT_W+1];
   side_type          side_ff [ROOT_W];

   assign x_c[0]    = sum_ff;
   assign rem_c[0]  = '0;
   assign root_c[0] = '0;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      tfn_sqrt_cell #(.IDX(ROOT_W - 1 - k)) u_cell (
         .clock   (clock),
         .x_up    (x_c[k]),
         .rem_up  (rem_c[k]),
         .root_up (root_c[k]),
         .x_dn    (x_c[k+1]),
         .rem_dn  (rem_c[k+1]),
         .root_dn (root_c[k+1])
      );
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{nm: nm4_ff, sign: sign4_ff, degen: degen4_ff};
      for (int j = 1; j < ROOT_W; j++) begin
         side_ff[j] <= side_ff[j-1];
      end
   end

   // stage 5: rounded numerators and divisor
   logic [2:0][NUM_W-1:0] num_ff;
   logic [ROOT_W-1:0]     den_ff;
   tag_type               tag5_ff;
   logic [ROOT_W-1:0]     len;

   assign len = root_c[ROOT_W];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= NUM_W'({side_ff[ROOT_W-1].nm[i], {UNIT_FRAC{1'b0}}})
                      + NUM_W'(len >> 1);
      end
      den_ff  <= len;
      tag5_ff <= '{sign: side_ff[ROOT_W-1].sign, degen: side_ff[ROOT_W-1].degen};
   end

   // three division lanes
   logic [2:0][QUO_W-1:0] quo;
   tag_type               tag_ff [QUO_W];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [NUM_W-1:0]  num_c [QUO_W+1];
      logic [ROOT_W-1:0] den_c [QUO_W+1];
      logic [ROOT_W-1:0] rem_c [QUO_W+1];
      logic [QUO_W-1:0]  quo_c [QUO_W+1];

      assign num_c[0] = num_ff[i];
      assign den_c[0] = den_ff;
      assign rem_c[0] = ROOT_W'(num_ff[i][NUM_W-1:QUO_W]);
      assign quo_c[0] = '0;

      for (genvar k = 0; k < QUO_W; k++) begin : g_div
         tfn_div_cell #(.IDX(QUO_W - 1 - k)) u_cell (
            .clock  (clock),
            .num_up (num_c[k]),
            .den_up (den_c[k]),
            .rem_up (rem_c[k]),
            .quo_up (quo_c[k]),
            .num_dn (num_c[k+1]),
            .den_dn (den_c[k+1]),
            .rem_dn (rem_c[k+1]),
            .quo_dn (quo_c[k+1])
         );
      end

      assign quo[i] = quo_c[QUO_W];
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag5_ff;
      for (int j = 1; j < QUO_W; j++) begin
         tag_ff[j] <= tag_ff[j-1];
      end
   end

   // stage 6: restore signs
   logic [2:0][U_W-1:0] unit_ff;
   logic                degen_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         unit_ff[i] <= tag_ff[QUO_W-1].sign[i] ? -U_W'(quo[i]) : U_W'(quo[i]);
      end
      degen_ff <= tag_ff[QUO_W-1].degen;
   end

   assign unit_vec = unit_ff;
   assign degen    = degen_ff;
endmodule

FILE: rtl/core/triangle_face_normal.sv
// The result word passes the edge register, the magnitude, shift, square and sum stages, 31 root
//   cells, a setup register, 31 divide cells, sign restore, products, differences and the rounded
//   output register.
// Throughput: one word per cycle; busy stays low and the result pipe never stalls.
// Reset clears only the valid line; words in flight are dropped and no strobe
//   follows until new words arrive. The receiver cannot stall.
module triangle_face_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tfn_pkg::rsp_type rsp_data
);
   localparam int CW       = tfn_pkg::COORD_WIDTH;
   localparam int NW       = tfn_pkg::NORMAL_WIDTH;
   localparam int EDGE_W   = tfn_pkg::EDGE_W;
   localparam int U_W      = tfn_pkg::U_W;
   localparam int PROD_W   = tfn_pkg::PROD_W;
   localparam int ROUND_SH = tfn_pkg::ROUND_SH;
   localparam int PIPE_LAT = tfn_pkg::PIPE_LAT;

   function automatic logic [NW-1:0] to_normal(input logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] r;
      logic [NW-1:0]     lim;
      mag = p[PROD_W-1] ? -p : p;
      r   = (mag + (PROD_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
      lim = {1'b0, {(NW-1){1'b1}}};
      if (r > PROD_W'(lim)) begin
         r = PROD_W'(lim);
      end
      return p[PROD_W-1] ? -r[NW-1:0] : r[NW-1:0];
   endfunction

   assign busy = 1'b0;

   // valid line
   logic [PIPE_LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], start};
      end
   end

   // edges b-a and c-a at full width
   logic [2:0][EDGE_W-1:0] e1_ff, e2_ff;

   function automatic logic [EDGE_W-1:0] sub_edge(input logic [CW-1:0] hi,
                                                  input logic [CW-1:0] lo);
      return {hi[CW-1], hi} - {lo[CW-1], lo};
   endfunction

   always_ff @(posedge clock) begin
      e1_ff[0] <= sub_edge(req_data.bx, req_data.ax);
      e1_ff[1] <= sub_edge(req_data.by, req_data.ay);
      e1_ff[2] <= sub_edge(req_data.bz, req_data.az);
      e2_ff[0] <= sub_edge(req_data.cx, req_data.ax);
      e2_ff[1] <= sub_edge(req_data.cy, req_data.ay);
      e2_ff[2] <= sub_edge(req_data.cz, req_data.az);
   end

   logic [2:0][U_W-1:0] u1, u2;
   logic                d1, d2;

   tfn_unit_edge u_edge1 (
      .clock    (clock),
      .edge_vec (e1_ff),
      .unit_vec (u1),
      .degen    (d1)
   );

   tfn_unit_edge u_edge2 (
      .clock    (clock),
      .edge_vec (e2_ff),
      .unit_vec (u2),
      .degen    (d2)
   );

   // cross product terms
   logic signed [PROD_W-1:0] p_ff [6];
   logic                     dg1_ff, dg2_ff;

   always_ff @(posedge clock) begin
      p_ff[0] <= $signed(u1[1]) * $signed(u2[2]);
      p_ff[1] <= $signed(u1[2]) * $signed(u2[1]);
      p_ff[2] <= $signed(u1[2]) * $signed(u2[0]);
      p_ff[3] <= $signed(u1[0]) * $signed(u2[2]);
      p_ff[4] <= $signed(u1[0]) * $signed(u2[1]);
      p_ff[5] <= $signed(u1[1]) * $signed(u2[0]);
      dg1_ff  <= d1 | d2;
   end

   logic [2:0][PROD_W-1:0] c_ff;

   always_ff @(posedge clock) begin
      c_ff[0] <= p_ff[0] - p_ff[1];
      c_ff[1] <= p_ff[2] - p_ff[3];
      c_ff[2] <= p_ff[4] - p_ff[5];
      dg2_ff  <= dg1_ff;
   end

   // round, saturate, zero on a degenerate triangle
   tfn_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.nx         <= dg2_ff ? '0 : to_normal(c_ff[0]);
      rsp_ff.ny         <= dg2_ff ? '0 : to_normal(c_ff[1]);
      rsp_ff.nz         <= dg2_ff ? '0 : to_normal(c_ff[2]);
      rsp_ff.degenerate <= dg2_ff;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = vld_ff[PIPE_LAT-1];

`ifndef SYNTH
   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_LAT))
      else $error("result word without a matching start");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.degenerate |->
         rsp_data.nx == '0 && rsp_data.ny == '0 && rsp_data.nz == '0)
      else $error("degenerate word with nonzero normal");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.nx != {1'b1, {(NW-1){1'b0}}}
         && rsp_data.ny != {1'b1, {(NW-1){1'b0}}}
         && rsp_data.nz != {1'b1, {(NW-1){1'b0}}})
      else $error("normal component outside saturation range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("strobe right after reset");
`endif
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT = 2000;
   localparam int LATENCY    = 72;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tfn_pkg::req_type req_data;
   logic             rsp_strobe;
   tfn_pkg::rsp_type rsp_data;

   triangle_face_normal dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // clock
   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   tfn_pkg::req_type pending_words[$];
   tfn_pkg::rsp_type expected_normals[$];
   int               error_count;
   int               idle_pct;
   int               quiet_cycles;

   task automatic report_mismatch(input string what);
      $display("tb_top: mismatch: %s", what);
      error_count++;
   endtask

   // predictor: scale an edge to unit length, Q30 components
   function automatic bit unit_edge(input logic signed [63:0] e[3],
                                    output logic signed [63:0] u[3]);
      logic [63:0] mag[3];
      logic [63:0] m, sum, len, x, r, bit_v, q;
      int bl;
      m = 0; sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = e[i] < 0 ? -e[i] : e[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 1'b0;
      bl = 0;
      x = m;
      while (x != 0) begin bl++; x = x >> 1; end
      for (int i = 0; i < 3; i++) begin
         if (bl > 30) mag[i] = mag[i] >> (bl - 30);
         else mag[i] = mag[i] << (30 - bl);
         sum += mag[i] * mag[i];
      end
      // integer square root
      x = sum; r = 0; bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x = x - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      len = r;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << 30) + (len >> 1)) / len;
         u[i] = e[i] < 0 ? -$signed(q) : $signed(q);
      end
      return 1'b1;
   endfunction

   // round Q60 product difference to Q2.14 with saturation
   function automatic logic signed [15:0] round_normal(input logic signed [63:0] p);
      logic [63:0] mag, r;
      mag = p < 0 ? -p : p;
      r = (mag + (64'd1 << 45)) >> 46;
      if (r > 64'd32767) r = 64'd32767;
      if (p < 0) r = -r;
      return r[15:0];
   endfunction

   function automatic tfn_pkg::rsp_type face_normal(input tfn_pkg::req_type w);
      logic signed [63:0] a[3], e1[3], e2[3], u1[3], u2[3];
      logic signed [31:0] coord[9];
      tfn_pkg::rsp_type n;
      coord = '{w.ax, w.ay, w.az, w.bx, w.by, w.bz, w.cx, w.cy, w.cz};
      for (int i = 0; i < 3; i++) begin
         a[i]  = coord[i];
         e1[i] = 64'(coord[3+i]) - a[i];
         e2[i] = 64'(coord[6+i]) - a[i];
      end
      n = '0;
      if (!unit_edge(e1, u1) || !unit_edge(e2, u2)) begin
         n.degenerate = 1'b1;
         return n;
      end
      n.nx = round_normal(u1[1] * u2[2] - u1[2] * u2[1]);
      n.ny = round_normal(u1[2] * u2[0] - u1[0] * u2[2]);
      n.nz = round_normal(u1[0] * u2[1] - u1[1] * u2[0]);
      return n;
   endfunction

   // driver: presents words at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy && pending_words.size() == 0) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_words[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // acceptance and response check at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (start && !busy) begin
            expected_normals = {expected_normals, face_normal(req_data)};
            void'(pending_words.pop_front());
         end
         if (rsp_strobe) begin
            if (expected_normals.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               tfn_pkg::rsp_type want;
               want = expected_normals.pop_front();
               if (rsp_data.nx !== want.nx)
                  report_mismatch($sformatf("nx got %0d want %0d", rsp_data.nx, want.nx));
               if (rsp_data.ny !== want.ny)
                  report_mismatch($sformatf("ny got %0d want %0d", rsp_data.ny, want.ny));
               if (rsp_data.nz !== want.nz)
                  report_mismatch($sformatf("nz got %0d want %0d", rsp_data.nz, want.nz));
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch($sformatf("degenerate got %0b want %0b",
                                            rsp_data.degenerate, want.degenerate));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic logic [31:0] pick_coord(input int style, input logic [31:0] base);
      case (style)
         0: return $urandom();
         1: return base + $urandom_range(255) - 128;
         2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return {{16{base[31]}}, base[15:0]} + $urandom_range(65535);
      endcase
   endfunction

   function automatic tfn_pkg::req_type random_triangle();
      tfn_pkg::req_type w;
      int style;
      logic [31:0] lo;
      style = $urandom_range(3);
      w.ax = $urandom(); w.ay = $urandom(); w.az = $urandom();
      if (style == 3) begin
         lo = $urandom_range(1000);
         w.ax = lo; w.ay = -lo; w.az = lo << 3;
      end
      w.bx = pick_coord(style, w.ax); w.by = pick_coord(style, w.ay);
      w.bz = pick_coord(style, w.az);
      w.cx = pick_coord(style, w.ax); w.cy = pick_coord(style, w.ay);
      w.cz = pick_coord(style, w.az);
      // occasional zero-length edge
      if ($urandom_range(19) == 0) begin w.bx = w.ax; w.by = w.ay; w.bz = w.az; end
      if ($urandom_range(19) == 0) begin w.cx = w.ax; w.cy = w.ay; w.cz = w.az; end
      return w;
   endfunction

   task automatic drain();
      while (pending_words.size() != 0 || start) @(posedge clock);
   endtask

   initial begin
      tfn_pkg::req_type w;
      error_count  = 0;
      quiet_cycles = 0;
      idle_pct     = 34;
      start        = 1'b0;
      req_data     = '0;
      reset        = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: unit axes, degenerate edges, extremes, collinear
      w = '0; w.bx = 32'h0001_0000; w.cy = 32'h0001_0000; pending_words = {pending_words, w};
      w = '0; w.by = 32'h0001_0000; w.cx = 32'h0001_0000; pending_words = {pending_words, w};
      w = '0; w.bz = 32'h0001_0000; w.cx = 32'h0001_0000; pending_words = {pending_words, w};
      w = '0; pending_words = {pending_words, w};
      w = '0; w.cx = 32'h0000_0001; pending_words = {pending_words, w};
      w = '0; w.bx = 32'h0000_0001; pending_words = {pending_words, w};
      w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      pending_words = {pending_words, w};
      w = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      pending_words = {pending_words, w};
      w = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffd};
      pending_words = {pending_words, w};
      // collinear corners
      w = '0; w.bx = 32'h0001_0000; w.by = 32'h0001_0000; w.bz = 32'h0001_0000;
      w.cx = 32'h0003_0000; w.cy = 32'h0003_0000; w.cz = 32'h0003_0000;
      pending_words = {pending_words, w};
      w = '0; w.bx = 32'h7fff_ffff; w.cx = 32'h8000_0000; pending_words = {pending_words, w};
      w = '{32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
            32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
            32'h0000_0001, 32'hffff_ffff, 32'h5555_5555};
      pending_words = {pending_words, w};
      w = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
            32'h0000_0003, 32'h0000_0004, 32'h0000_0000,
            32'hfffc_0000, 32'h0003_0000, 32'h0000_0001};
      pending_words = {pending_words, w};
      drain();

      // random phases: sender idles at 34%, then 76%, then not at all
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 34 : (ph == 1) ? 76 : 0;
         for (int i = 0; i < 130; i++) pending_words = {pending_words, random_triangle()};
         drain();
      end

      while (expected_normals.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
